FILE: design/dqs_pkg.sv
package dqs_pkg;

	// default store depth and entry width
	localparam int unsigned DQS_DEPTH = 128;
	localparam int unsigned DQS_DW    = 32;
	localparam int unsigned DQS_CW    = 8;

	// request codes; the unused code falls to a default arm
	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_CLEAR      = 3'd4,
		REQ_REVERSE    = 3'd5,
		REQ_SORT       = 3'd6
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} res_status_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_REV_CHK,
		S_REV_RD,
		S_REV_WA,
		S_REV_WB,
		S_SORT_CHK,
		S_SORT_RD,
		S_SORT_CMP,
		S_SORT_WB,
		S_FIN_RD,
		S_LOAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic rd_ht;
		logic rd_ij;
		logic wr_i_b;
		logic wr_j_a;
		logic rev_adv;
		logic sort_adv;
		logic load;
	} dqs_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_t req;
		logic holds;
		logic rev_more;
		logic sort_more;
		logic gt;
		logic out_free;
	} dqs_stat_t;

endpackage

FILE: design/dqs_req_if.sv
interface dqs_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [31:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

FILE: design/dqs_res_if.sv
interface dqs_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] popped_value;
	logic [1:0]         status;
	logic [7:0]         entry_count;
	logic               is_empty;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;

	modport source (
		output valid, output popped_value, output status, output entry_count,
		output is_empty, output front_value, output back_value, input ready
	);
	modport sink (
		input valid, input popped_value, input status, input entry_count,
		input is_empty, input front_value, input back_value, output ready
	);
endinterface

FILE: design/array_deque_with_sort_top.sv
// double-ended queue in a fixed array of DEPTH signed 32-bit entries, with
// reverse and ascending sort over the held entries
// req channel: one word per request (req_type, push_value); res channel: one
// word per request with popped_value, status, entry_count, is_empty and the
// front and back entries after the request
// push, pop, clear and the unused code pass EXEC, FIN_RD and LOAD after the
// request is accepted; a new request is taken only once the last is through
// reverse runs REV_CHK, REV_RD, REV_WA and REV_WB per swapped pair; sort of n
// entries runs SORT_CHK, SORT_RD, SORT_CMP and, on an exchange, SORT_WB for
// each of n*(n-1)/2 compares, and both then end in FIN_RD and LOAD; both are
// bound by the single write port and the registered reads of the store
// ready is high only while no request is in work
// a finished result sits in an output register; the next request is accepted
// and run while it waits, and only the hand-over of that next result waits for
// the receiver, so a stalled receiver holds back at most one request
// reset clears the indices and leaves the deque empty; the store is not cleared,
// and values read from it while the deque is empty are zeroed in the result
module array_deque_with_sort_top #(
	parameter int unsigned DEPTH = dqs_pkg::DQS_DEPTH
) (
	input logic      clk,
	input logic      arst_n,
	dqs_req_if.sink  req,
	dqs_res_if.source res
);
	import dqs_pkg::*;

	dqs_cmd_t  cmd;
	dqs_stat_t stat;

	// request sequencing
	dqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store, indices and result register
	dqs_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_type    (req.req_type),
		.in_value   (req.push_value),
		.out_ready  (res.ready),
		.out_valid  (res.valid),
		.out_popped (res.popped_value),
		.out_status (res.status),
		.out_count  (res.entry_count),
		.out_empty  (res.is_empty),
		.out_front  (res.front_value),
		.out_back   (res.back_value)
	);

endmodule

FILE: design/dqs_ctrl.sv
module dqs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dqs_pkg::dqs_stat_t  stat,
	output dqs_pkg::dqs_cmd_t   cmd
);
	import dqs_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (stat.req)
					REQ_REVERSE: state_d = stat.holds ? S_REV_CHK : S_FIN_RD;
					REQ_SORT:    state_d = stat.holds ? S_SORT_CHK : S_FIN_RD;
					default:     state_d = S_FIN_RD;
				endcase
			end
			S_REV_CHK:  state_d = stat.rev_more ? S_REV_RD : S_FIN_RD;
			S_REV_RD:   state_d = S_REV_WA;
			S_REV_WA:   state_d = S_REV_WB;
			S_REV_WB:   state_d = S_REV_CHK;
			S_SORT_CHK: state_d = stat.sort_more ? S_SORT_RD : S_FIN_RD;
			S_SORT_RD:  state_d = S_SORT_CMP;
			S_SORT_CMP: state_d = stat.gt ? S_SORT_WB : S_SORT_CHK;
			S_SORT_WB:  state_d = S_SORT_CHK;
			S_FIN_RD:   state_d = S_LOAD;
			S_LOAD: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		in_ready     = (state_q == S_IDLE);
		cmd          = '0;
		cmd.take     = (state_q == S_IDLE) && in_valid;
		cmd.exec     = (state_q == S_EXEC);
		cmd.rd_ij    = (state_q == S_REV_RD) || (state_q == S_SORT_RD);
		cmd.wr_i_b   = (state_q == S_REV_WA) || ((state_q == S_SORT_CMP) && stat.gt);
		cmd.wr_j_a   = (state_q == S_REV_WB) || (state_q == S_SORT_WB);
		cmd.rev_adv  = (state_q == S_REV_WB);
		cmd.sort_adv = ((state_q == S_SORT_CMP) && !stat.gt) || (state_q == S_SORT_WB);
		cmd.rd_ht    = (state_q == S_FIN_RD);
		cmd.load     = (state_q == S_LOAD) && stat.out_free;
	end

endmodule

FILE: design/dqs_dpath.sv
module dqs_dpath #(
	parameter int unsigned DEPTH = dqs_pkg::DQS_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dqs_pkg::dqs_cmd_t   cmd,
	output dqs_pkg::dqs_stat_t  stat,
	input  logic [2:0]          in_type,
	input  logic [31:0]         in_value,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [31:0]         out_popped,
	output logic [1:0]          out_status,
	output logic [dqs_pkg::DQS_CW-1:0] out_count,
	output logic                out_empty,
	output logic [31:0]         out_front,
	output logic [31:0]         out_back
);
	import dqs_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = AW + 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [DQS_DW-1:0] entry_store [DEPTH];

	// control state
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic          holds_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic          out_valid_q;

	// payload
	req_t              req_q;
	logic [DQS_DW-1:0] val_q;
	logic [DQS_DW-1:0] rd_a_q;
	logic [DQS_DW-1:0] rd_b_q;
	logic [DQS_DW-1:0] front_q;
	logic [DQS_DW-1:0] back_q;
	logic [DQS_DW-1:0] res_pop_q;
	res_status_t       res_st_q;
	logic [DQS_DW-1:0] out_popped_q;
	res_status_t       out_status_q;
	logic [DQS_CW-1:0] out_count_q;
	logic              out_empty_q;
	logic [DQS_DW-1:0] out_front_q;
	logic [DQS_DW-1:0] out_back_q;

	// write port, read addresses, request outcome
	logic              we;
	logic [AW-1:0]     wa;
	logic [DQS_DW-1:0] wd;
	logic              rd_en;
	logic [AW-1:0]     ra;
	logic [AW-1:0]     rb;
	res_status_t       exec_st;
	logic [DQS_DW-1:0] exec_pop;
	logic [NW-1:0]     cnt;
	logic [NW+DQS_CW-1:0] cnt_ext;

	// store write select and request outcome
	always_comb begin
		we       = 1'b0;
		wa       = '0;
		wd       = val_q;
		exec_st  = ST_DONE;
		exec_pop = '0;
		if (cmd.exec) begin
			case (req_q)
				REQ_PUSH_FRONT: begin
					if (!holds_q) begin
						we = 1'b1;
					end else if (head_q != '0) begin
						we = 1'b1;
						wa = head_q - AW'(1);
					end else begin
						exec_st = ST_PUSH_FULL;
					end
				end
				REQ_PUSH_BACK: begin
					if (!holds_q) begin
						we = 1'b1;
					end else if (tail_q != LAST) begin
						we = 1'b1;
						wa = tail_q + AW'(1);
					end else begin
						exec_st = ST_PUSH_FULL;
					end
				end
				REQ_POP_FRONT: begin
					if (!holds_q) exec_st = ST_POP_EMPTY;
					else exec_pop = front_q;
				end
				REQ_POP_BACK: begin
					if (!holds_q) exec_st = ST_POP_EMPTY;
					else exec_pop = back_q;
				end
				default: begin
				end
			endcase
		end else if (cmd.wr_i_b) begin
			we = 1'b1;
			wa = i_q;
			wd = rd_b_q;
		end else if (cmd.wr_j_a) begin
			we = 1'b1;
			wa = j_q;
			wd = rd_a_q;
		end
	end

	// read port select
	always_comb begin
		rd_en = cmd.rd_ht || cmd.rd_ij;
		ra    = cmd.rd_ht ? head_q : i_q;
		rb    = cmd.rd_ht ? tail_q : j_q;
	end

	// entry store
	always_ff @(posedge clk) begin
		if (we) entry_store[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= entry_store[ra];
			rd_b_q <= entry_store[rb];
		end
	end

	// indices, walk pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			holds_q     <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				case (req_q)
					REQ_PUSH_FRONT: begin
						if (!holds_q) begin
							head_q  <= '0;
							tail_q  <= '0;
							holds_q <= 1'b1;
						end else if (head_q != '0) begin
							head_q <= head_q - AW'(1);
						end
					end
					REQ_PUSH_BACK: begin
						if (!holds_q) begin
							head_q  <= '0;
							tail_q  <= '0;
							holds_q <= 1'b1;
						end else if (tail_q != LAST) begin
							tail_q <= tail_q + AW'(1);
						end
					end
					REQ_POP_FRONT: begin
						if (holds_q) begin
							if (head_q == tail_q) begin
								head_q  <= '0;
								tail_q  <= '0;
								holds_q <= 1'b0;
							end else begin
								head_q <= head_q + AW'(1);
							end
						end
					end
					REQ_POP_BACK: begin
						if (holds_q) begin
							if (head_q == tail_q) begin
								head_q  <= '0;
								tail_q  <= '0;
								holds_q <= 1'b0;
							end else begin
								tail_q <= tail_q - AW'(1);
							end
						end
					end
					REQ_CLEAR: begin
						head_q  <= '0;
						tail_q  <= '0;
						holds_q <= 1'b0;
					end
					REQ_REVERSE: begin
						i_q <= head_q;
						j_q <= tail_q;
					end
					REQ_SORT: begin
						i_q <= head_q;
						j_q <= head_q + AW'(1);
					end
					default: begin
					end
				endcase
			end
			// reverse walks inward, sort walks the inner index then the outer
			if (cmd.rev_adv) begin
				i_q <= i_q + AW'(1);
				j_q <= j_q - AW'(1);
			end
			if (cmd.sort_adv) begin
				if (j_q < tail_q) begin
					j_q <= j_q + AW'(1);
				end else begin
					i_q <= i_q + AW'(1);
					j_q <= i_q + AW'(2);
				end
			end
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// entry count, cut to the result field
	always_comb begin
		cnt     = {1'b0, tail_q} - {1'b0, head_q} + NW'(1);
		cnt_ext = {DQS_CW'(0), cnt};
	end

	// request word, outcome staging, end caches and result word
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= req_t'(in_type);
			val_q <= in_value;
		end
		if (cmd.exec) begin
			res_st_q  <= exec_st;
			res_pop_q <= exec_pop;
		end
		if (cmd.load) begin
			front_q      <= rd_a_q;
			back_q       <= rd_b_q;
			out_popped_q <= res_pop_q;
			out_status_q <= res_st_q;
			out_count_q  <= holds_q ? cnt_ext[DQS_CW-1:0] : '0;
			out_empty_q  <= !holds_q;
			out_front_q  <= holds_q ? rd_a_q : '0;
			out_back_q   <= holds_q ? rd_b_q : '0;
		end
	end

	// status to controller
	always_comb begin
		stat.req       = req_q;
		stat.holds     = holds_q;
		stat.rev_more  = (i_q < j_q);
		stat.sort_more = (i_q < tail_q);
		stat.gt        = ($signed(rd_a_q) > $signed(rd_b_q));
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_popped = out_popped_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;
	assign out_empty  = out_empty_q;
	assign out_front  = out_front_q;
	assign out_back   = out_back_q;

endmodule

FILE: sim/tb_array_deque_with_sort_top.sv
module tb_array_deque_with_sort_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dqs_pkg::*;

	localparam int DEPTH      = DQS_DEPTH;
	localparam int CYCLE_CAP  = 1000000;
	localparam int LONG_HOLD  = 300;
	localparam int SORT_SMALL = 16;
	localparam logic [2:0] REQ_UNUSED = 3'd7;

	typedef struct {
		logic [2:0]         code;
		logic signed [31:0] value;
	} deque_req_t;

	typedef struct {
		logic signed [31:0] popped;
		res_status_t        status;
		logic [7:0]         count;
		logic               is_empty;
		logic signed [31:0] front;
		logic signed [31:0] back;
	} deque_res_t;

	logic clk = 1'b0;
	logic arst_n;

	dqs_req_if req_if ();
	dqs_res_if res_if ();

	array_deque_with_sort_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if)
	);

	always #5 clk = ~clk;

	// predicted deque contents and indices
	logic signed [31:0] dq_mem [0:DEPTH-1];
	int                 dq_head;
	int                 dq_tail;
	bit                 dq_held;

	// index shadow used only to shape stimulus
	int sh_head = 0;
	int sh_tail = 0;
	bit sh_held = 1'b0;

	deque_req_t req_pending [$];
	deque_res_t res_expected [$];

	bit  idle_en     = 1'b0;
	int  n_sent      = 0;
	int  big_sorts   = 0;
	int  mismatches  = 0;
	int  rx_hold_ask = 0;

	// driver-side state
	deque_req_t tx_item;
	bit         tx_busy;
	int         tx_gap;

	// monitor-side state
	int rx_hold;
	int rx_hold_done;

	// work out the result word of one accepted request
	task automatic deque_apply(input logic [2:0] code, input logic signed [31:0] v);
		deque_res_t         r;
		logic signed [31:0] t;
		int                 i;
		int                 j;
		r.popped = '0;
		r.status = ST_DONE;
		case (code)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (!dq_held) begin
					dq_head = 0;
					dq_tail = 0;
					dq_held = 1'b1;
					dq_mem[0] = v;
				end else if (code == REQ_PUSH_FRONT && dq_head > 0) begin
					dq_head--;
					dq_mem[dq_head] = v;
				end else if (code == REQ_PUSH_BACK && dq_tail < DEPTH - 1) begin
					dq_tail++;
					dq_mem[dq_tail] = v;
				end else begin
					r.status = ST_PUSH_FULL;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (!dq_held) begin
					r.status = ST_POP_EMPTY;
				end else begin
					r.popped = (code == REQ_POP_FRONT) ? dq_mem[dq_head] : dq_mem[dq_tail];
					if (dq_head == dq_tail) begin
						dq_held = 1'b0;
						dq_head = 0;
						dq_tail = 0;
					end else if (code == REQ_POP_FRONT) begin
						dq_head++;
					end else begin
						dq_tail--;
					end
				end
			end
			REQ_CLEAR: begin
				dq_held = 1'b0;
				dq_head = 0;
				dq_tail = 0;
			end
			REQ_REVERSE: begin
				if (dq_held) begin
					i = dq_head;
					j = dq_tail;
					while (i < j) begin
						t = dq_mem[i];
						dq_mem[i] = dq_mem[j];
						dq_mem[j] = t;
						i++;
						j--;
					end
				end
			end
			REQ_SORT: begin
				// exchange sort, signed ascending
				if (dq_held) begin
					for (i = dq_head; i <= dq_tail; i++) begin
						for (j = i + 1; j <= dq_tail; j++) begin
							if (dq_mem[i] > dq_mem[j]) begin
								t = dq_mem[i];
								dq_mem[i] = dq_mem[j];
								dq_mem[j] = t;
							end
						end
					end
				end
			end
			default: ;
		endcase
		r.count    = dq_held ? 8'(dq_tail - dq_head + 1) : 8'd0;
		r.is_empty = !dq_held;
		r.front    = dq_held ? dq_mem[dq_head] : '0;
		r.back     = dq_held ? dq_mem[dq_tail] : '0;
		res_expected.insert(res_expected.size(), r);
	endtask

	function automatic int shadow_count();
		return sh_held ? sh_tail - sh_head + 1 : 0;
	endfunction

	// queue one request and track where the indices will stand
	task automatic queue_req(input logic [2:0] code, input logic signed [31:0] v);
		deque_req_t it;
		it.code  = code;
		it.value = v;
		req_pending.insert(req_pending.size(), it);
		if (code != REQ_UNUSED)
			n_sent++;
		case (code)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (!sh_held) begin
					sh_held = 1'b1;
					sh_head = 0;
					sh_tail = 0;
				end else if (code == REQ_PUSH_FRONT && sh_head > 0) begin
					sh_head--;
				end else if (code == REQ_PUSH_BACK && sh_tail < DEPTH - 1) begin
					sh_tail++;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (sh_held && sh_head == sh_tail) begin
					sh_held = 1'b0;
					sh_head = 0;
					sh_tail = 0;
				end else if (sh_held && code == REQ_POP_FRONT) begin
					sh_head++;
				end else if (sh_held) begin
					sh_tail--;
				end
			end
			REQ_CLEAR: begin
				sh_held = 1'b0;
				sh_head = 0;
				sh_tail = 0;
			end
			default: ;
		endcase
	endtask

	// full range mostly, some extremes and small values to force ties
	function automatic logic signed [31:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return 32'sh0000_0000;
				default: return 32'shffff_ffff;
			endcase
		end else if (r < 3) begin
			return $signed(32'($urandom_range(0, 8))) - 32'sd4;
		end
		return $signed(32'($urandom));
	endfunction

	// one block of well-formed traffic with random content
	task automatic queue_phase();
		int n;
		int k;
		int r;
		case ($urandom_range(0, 9))
			4, 5: begin
				// fill to the top slot, then push past it
				while (!(sh_held && sh_tail == DEPTH - 1))
					queue_req(REQ_PUSH_BACK, pick_value());
				k = $urandom_range(1, 3);
				repeat (k) queue_req(REQ_PUSH_BACK, pick_value());
				if ($urandom_range(0, 1) == 0)
					queue_req(REQ_REVERSE, pick_value());
				if (big_sorts == 0 || (big_sorts < 2 && $urandom_range(0, 3) == 0)) begin
					queue_req(REQ_SORT, pick_value());
					big_sorts++;
				end
			end
			6, 7: begin
				// drain from both ends, then pop on empty
				while (sh_held)
					queue_req($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
				k = $urandom_range(1, 2);
				repeat (k)
					queue_req($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
			end
			8, 9: begin
				// open room below the head and push front past it
				if (shadow_count() < 2) begin
					k = $urandom_range(2, 8);
					repeat (k) queue_req(REQ_PUSH_BACK, pick_value());
				end
				n = $urandom_range(1, (shadow_count() > 20) ? 20 : shadow_count() - 1);
				repeat (n) queue_req(REQ_POP_FRONT, pick_value());
				k = n + $urandom_range(1, 2);
				repeat (k) queue_req(REQ_PUSH_FRONT, pick_value());
				if (shadow_count() <= SORT_SMALL)
					queue_req(REQ_SORT, pick_value());
			end
			default: begin
				n = $urandom_range(20, 60);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 28)
						queue_req(REQ_PUSH_FRONT, pick_value());
					else if (r < 56)
						queue_req(REQ_PUSH_BACK, pick_value());
					else if (r < 72)
						queue_req(REQ_POP_FRONT, pick_value());
					else if (r < 88)
						queue_req(REQ_POP_BACK, pick_value());
					else if (r < 92)
						queue_req(REQ_REVERSE, pick_value());
					else if (r < 96)
						queue_req(shadow_count() <= SORT_SMALL ? REQ_SORT : REQ_REVERSE,
							pick_value());
					else if (r < 98)
						queue_req(REQ_CLEAR, pick_value());
					else
						queue_req(REQ_UNUSED, pick_value());
				end
			end
		endcase
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			tx_busy = 1'b0;
			tx_gap  = 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				deque_apply(tx_item.code, tx_item.value);
				tx_busy = 1'b0;
			end
			if (!tx_busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req_if.valid <= 1'b0;
				end else if (req_pending.size() > 0) begin
					tx_item = req_pending[0];
					req_pending.delete(0);
					req_if.valid      <= 1'b1;
					req_if.req_type   <= tx_item.code;
					req_if.push_value <= tx_item.value;
					tx_busy = 1'b1;
					if (idle_en && $urandom_range(0, 5) == 0)
						tx_gap = $urandom_range(1, 12);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		deque_res_t e;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			rx_hold      = 0;
			rx_hold_done = 0;
		end else begin
			// compare an accepted word against the oldest prediction
			if (res_if.valid && res_if.ready) begin
				if (res_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: popped=%0d st=%0d cnt=%0d",
							res_if.popped_value, res_if.status, res_if.entry_count);
				end else begin
					e = res_expected[0];
					res_expected.delete(0);
					if (res_if.popped_value !== e.popped || res_if.status !== e.status ||
						res_if.entry_count !== e.count || res_if.is_empty !== e.is_empty ||
						res_if.front_value !== e.front || res_if.back_value !== e.back) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: exp popped=%0d st=%0d cnt=%0d empty=%0b ",
								"front=%0d back=%0d; got popped=%0d st=%0d cnt=%0d empty=%0b ",
								"front=%0d back=%0d"},
								e.popped, e.status, e.count, e.is_empty, e.front, e.back,
								res_if.popped_value, res_if.status, res_if.entry_count,
								res_if.is_empty, res_if.front_value, res_if.back_value);
					end
				end
			end
			// ready: long hold on request, short random stalls otherwise
			if (rx_hold_done < rx_hold_ask) begin
				rx_hold_done++;
				rx_hold = LONG_HOLD;
				res_if.ready <= 1'b0;
			end else if (rx_hold > 0) begin
				rx_hold--;
				res_if.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				rx_hold = $urandom_range(0, 11);
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// run limit
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		bit held_off;
		bit paused;
		held_off = 1'b0;
		paused   = 1'b0;
		arst_n = 1'b0;
		req_if.valid      = 1'b0;
		req_if.req_type   = REQ_PUSH_FRONT;
		req_if.push_value = '0;
		res_if.ready      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty-deque cases, single entry, no room, extremes, each op
		idle_en = 1'b1;
		queue_req(REQ_POP_FRONT, 32'sd0);
		queue_req(REQ_POP_BACK, 32'sd0);
		queue_req(REQ_REVERSE, 32'sd0);
		queue_req(REQ_SORT, 32'sd0);
		queue_req(REQ_UNUSED, 32'sd0);
		queue_req(REQ_PUSH_FRONT, 32'sh8000_0000);
		queue_req(REQ_REVERSE, 32'sd0);
		queue_req(REQ_SORT, 32'sd0);
		queue_req(REQ_PUSH_FRONT, 32'sd5);
		queue_req(REQ_PUSH_BACK, 32'sh7fff_ffff);
		queue_req(REQ_PUSH_BACK, 32'shffff_ffff);
		queue_req(REQ_PUSH_BACK, 32'sd0);
		queue_req(REQ_PUSH_BACK, 32'sd1);
		queue_req(REQ_SORT, 32'sd0);
		queue_req(REQ_REVERSE, 32'sd0);
		queue_req(REQ_POP_FRONT, 32'sd0);
		queue_req(REQ_POP_BACK, 32'sd0);
		queue_req(REQ_UNUSED, 32'sh7fff_ffff);
		queue_req(REQ_CLEAR, 32'sd0);
		queue_req(REQ_PUSH_BACK, 32'sh5555_5555);
		queue_req(REQ_POP_BACK, 32'sd0);
		queue_req(REQ_PUSH_FRONT, 32'shaaaa_aaaa);
		queue_req(REQ_POP_FRONT, 32'sd0);
		while (req_pending.size() > 0) @(negedge clk);

		// random traffic in blocks
		while (n_sent < 1600) begin
			idle_en = ($urandom_range(0, 3) != 0);
			if (!held_off && n_sent >= 500) begin
				// receiver holds off while requests keep coming
				rx_hold_ask++;
				held_off = 1'b1;
			end
			if (!paused && n_sent >= 900) begin
				// sender waits for every outstanding result
				while (req_pending.size() > 0 || tx_busy || res_expected.size() > 0)
					@(negedge clk);
				paused = 1'b1;
			end
			queue_phase();
			while (req_pending.size() > 0) @(negedge clk);
		end

		// closing stretch at full rate
		idle_en = 1'b0;
		while (n_sent < 1750) begin
			queue_phase();
			while (req_pending.size() > 0) @(negedge clk);
		end

		while (req_pending.size() > 0 || tx_busy || res_expected.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (mismatches == 0 && res_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: array_deque_with_sort_top.f
design/dqs_pkg.sv
design/dqs_req_if.sv
design/dqs_res_if.sv
design/dqs_ctrl.sv
design/dqs_dpath.sv
design/array_deque_with_sort_top.sv
sim/tb_array_deque_with_sort_top.sv
